// File: design/hsm3_pkg.sv
// ----------------------------------------------------------------------------
// hsm3_pkg: shared definitions for the HSV skin mask with 3x3 median
// Register map, reset values, the operation record passed from the front end
// to the back end, and the one-bit majority function.
// ----------------------------------------------------------------------------
package hsm3_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int PIX_W      = 8;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int ROW_W      = FH_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [PIX_W-1:0] HUE_LOW_RST  = 8'd2;
	localparam logic [PIX_W-1:0] HUE_HIGH_RST = 8'd15;
	localparam logic [PIX_W-1:0] SAT_LOW_RST  = 8'd60;
	localparam logic [PIX_W-1:0] SAT_HIGH_RST = 8'd200;
	localparam logic [PIX_W-1:0] VAL_LOW_RST  = 8'd40;
	localparam logic [PIX_W-1:0] VAL_HIGH_RST = 8'd200;
	localparam logic [FW_W-1:0]  WIDTH_RST    = 11'd640;
	localparam logic [FH_W-1:0]  HEIGHT_RST   = 12'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_LOW      = 3'd0,
		REG_HUE_HIGH     = 3'd1,
		REG_SAT_LOW      = 3'd2,
		REG_SAT_HIGH     = 3'd3,
		REG_VAL_LOW      = 3'd4,
		REG_VAL_HIGH     = 3'd5,
		REG_FRAME_WIDTH  = 3'd6,
		REG_FRAME_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_LINE  = 1'b0,
		OP_FINAL = 1'b1
	} op_kind_t;

	// Classification of one queued item.
	typedef struct packed {
		op_kind_t kind;
		logic     thr;     // thresholded mask bit of the pixel
		logic     bottom;  // flush row: replicate the last mask row
		logic     top;     // first centre row: replicate the first mask row
		logic     act;     // a centre row exists, so the window moves
		logic     pend;    // first column: the previous row's last result is due
	} op_flags_t;

	// Majority of nine bits, the median of a one-bit 3x3 window.
	function automatic logic maj9(input logic [8:0] bits);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(bits[i]);
		end
		return n >= 4'd5;
	endfunction

endpackage

// File: design/hsm3_if.sv
// ----------------------------------------------------------------------------
// hsm3 channel interfaces
// Pixel input, result output and register write channels, each with
// valid/ready handshaking.
// ----------------------------------------------------------------------------
interface hsm3_pix_if import hsm3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] hue;
	logic [PIX_W-1:0] sat;
	logic [PIX_W-1:0] bright;

	modport source(output valid, mode, hue, sat, bright, input ready);
	modport sink(input valid, mode, hue, sat, bright, output ready);
endinterface

interface hsm3_res_if import hsm3_pkg::*; ();
	logic valid;
	logic ready;
	logic skin_bit;
	logic row_end;
	logic frame_end;

	modport source(output valid, skin_bit, row_end, frame_end, input ready);
	modport sink(input valid, skin_bit, row_end, frame_end, output ready);
endinterface

interface hsm3_cfg_if import hsm3_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: design/hsm3_ram.sv
// ----------------------------------------------------------------------------
// hsm3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsm3_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/hsm3_queue.sv
// ----------------------------------------------------------------------------
// hsm3_queue: short FIFO between the front and back ends
// Flip-flop storage, registered occupancy count.
// ----------------------------------------------------------------------------
module hsm3_queue #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full  = count_q == NW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/hsm3_front.sv
// ----------------------------------------------------------------------------
// hsm3_front: register file, thresholding and raster position tracking
// Classifies each accepted item and pushes its operation into the queue,
// apart from a stray flush tick, which is discarded.
module hsm3_front import hsm3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	hsm3_pix_if.sink        pix,
	hsm3_cfg_if.sink        cfg,
	input  logic            q_full,
	output logic            q_push,
	output op_flags_t       q_flags,
	output logic [CW-1:0]   q_col
);

	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	logic [PIX_W-1:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q;
	logic [PIX_W-1:0] val_low_q, val_high_q;
	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [WW-1:0]    width_eff;
	logic [ROW_W-1:0] height_eff;
	logic             accept, in_win, drop, is_final, row_done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= HUE_LOW_RST;
			hue_high_q <= HUE_HIGH_RST;
			sat_low_q  <= SAT_LOW_RST;
			sat_high_q <= SAT_HIGH_RST;
			val_low_q  <= VAL_LOW_RST;
			val_high_q <= VAL_HIGH_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_HUE_LOW:      hue_low_q  <= cfg.data[PIX_W-1:0];
				REG_HUE_HIGH:     hue_high_q <= cfg.data[PIX_W-1:0];
				REG_SAT_LOW:      sat_low_q  <= cfg.data[PIX_W-1:0];
				REG_SAT_HIGH:     sat_high_q <= cfg.data[PIX_W-1:0];
				REG_VAL_LOW:      val_low_q  <= cfg.data[PIX_W-1:0];
				REG_VAL_HIGH:     val_high_q <= cfg.data[PIX_W-1:0];
				REG_FRAME_WIDTH:  width_q    <= cfg.data[FW_W-1:0];
				REG_FRAME_HEIGHT: height_q   <= cfg.data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range geometry is clamped: a zero width or height acts as one.
	always_comb begin
		if (width_q == '0) begin
			width_eff = WW'(1);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(width_q);
		end
		height_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
	end

	assign in_win = (pix.hue >= hue_low_q) && (pix.hue <= hue_high_q) &&
	                (pix.sat >= sat_low_q) && (pix.sat <= sat_high_q) &&
	                (pix.bright >= val_low_q) && (pix.bright <= val_high_q);

	assign pix.ready = !q_full;
	assign accept    = pix.valid && pix.ready;

	// A flush tick arriving while pixels are still expected is discarded.
	assign drop     = (row_q < height_eff) && pix.mode;
	assign is_final = row_q > height_eff;
	assign row_done = (WW'(col_q) + WW'(1)) >= width_eff;

	assign q_push         = accept && !drop;
	assign q_col          = col_q;
	assign q_flags.kind   = is_final ? OP_FINAL : OP_LINE;
	assign q_flags.thr    = (row_q < height_eff) && in_win;
	assign q_flags.bottom = row_q == height_eff;
	assign q_flags.top    = row_q == ROW_W'(1);
	assign q_flags.act    = row_q != '0;
	assign q_flags.pend   = (row_q >= ROW_W'(2)) && (col_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (is_final) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_done) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// File: design/hsm3_back.sv
// ----------------------------------------------------------------------------
// hsm3_back: line buffers, 3x3 window and majority output
// Reads the line store, updates the window and drives the result register.
// ----------------------------------------------------------------------------
module hsm3_back import hsm3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  op_flags_t     q_flags,
	input  logic [CW-1:0] q_col,
	output logic          q_pop,
	hsm3_res_if.source    res
);

	logic          s1_valid_q;
	op_flags_t     flags_s1;
	logic [CW-1:0] col_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;

	logic [8:0]    window_q;
	logic          res_valid_q, skin_q, row_end_q, frame_end_q;

	logic          s1_done;
	logic [1:0]    rd_data, ram_word;
	logic          wr_en;
	logic [1:0]    wr_data;
	logic          mid, up, nb;
	logic [2:0]    col3;
	logic [8:0]    shifted, win_next;
	logic          emit, emit_skin, emit_row_end, emit_frame_end;

	// Each entry holds {row two above, row one above} for one column.
	hsm3_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(col_s1),
		.wr_data(wr_data),
		.rd_en  (q_pop),
		.rd_addr(q_col),
		.rd_data(rd_data)
	);

	assign s1_done = s1_valid_q && (!res_valid_q || res.ready);
	assign q_pop   = !q_empty && (!s1_valid_q || s1_done);

	// A read issued in the same cycle as a write to the same column sees
	// the old word, so the written word is carried alongside.
	assign ram_word = fwd_s1 ? fwd_data_s1 : rd_data;
	assign mid      = ram_word[0];
	assign up       = flags_s1.top ? mid : ram_word[1];
	assign nb       = flags_s1.bottom ? mid : flags_s1.thr;
	assign col3     = {nb, mid, up};
	assign shifted  = (col_s1 == '0) ? {col3, col3, col3} : {window_q[5:0], col3};

	assign wr_en   = s1_done && (flags_s1.kind == OP_LINE);
	assign wr_data = {mid, nb};

	always_comb begin
		win_next       = window_q;
		emit           = 1'b0;
		emit_skin      = maj9({window_q[5:0], window_q[2:0]});
		emit_row_end   = 1'b0;
		emit_frame_end = 1'b0;
		unique case (flags_s1.kind)
			OP_FINAL: begin
				win_next       = '0;
				emit           = 1'b1;
				emit_row_end   = 1'b1;
				emit_frame_end = 1'b1;
			end
			OP_LINE: begin
				if (flags_s1.act) begin
					win_next = shifted;
				end
				if (flags_s1.pend) begin
					emit         = 1'b1;
					emit_row_end = 1'b1;
				end else if (flags_s1.act && (col_s1 != '0)) begin
					emit      = 1'b1;
					emit_skin = maj9(shifted);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			window_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done) begin
				window_q <= win_next;
			end
			if (s1_done && emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_s1    <= q_flags;
			col_s1      <= q_col;
			fwd_s1      <= wr_en && (col_s1 == q_col);
			fwd_data_s1 <= wr_data;
		end
		if (s1_done && emit) begin
			skin_q      <= emit_skin;
			row_end_q   <= emit_row_end;
			frame_end_q <= emit_frame_end;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.skin_bit  = skin_q;
	assign res.row_end   = row_end_q;
	assign res.frame_end = frame_end_q;

endmodule

// File: design/hsv_skin_mask_median3_core.sv
// Throughput: one pixel or flush transfer per clock while results are taken.
// A result reaches the result register from the transfer that completes its
// window through the queue slot and the line store read stage.
// In stream terms a result lags its pixel by one row plus one pixel.
// Reset clears registers, counters, window and queue; line store is not cleared.
// ----------------------------------------------------------------------------
// hsv_skin_mask_median3_core: HSV skin mask with 3x3 majority filter
// Streams HSV pixels in raster order, thresholds them into a one-bit mask
// and filters the mask with a 3x3 median, edges replicated.
// ----------------------------------------------------------------------------
module hsv_skin_mask_median3_core import hsm3_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hsm3_pix_if.sink   pix,
	hsm3_cfg_if.sink   cfg,
	hsm3_res_if.source res
);

	// Column counter width: enough to address every entry of a line.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = $bits(op_flags_t) + CW;

	// Front end: the register file, the threshold comparators and the raster
	// position counters. It decides for every pixel transfer whether the item
	// is a live pixel, a flush column of the bottom border, the frame's final
	// pending result, or a stray flush that is discarded. Its ready depends
	// only on queue occupancy, so the pixel side never waits on the result side
	// combinationally.
	logic          f_push;
	op_flags_t     f_flags;
	logic [CW-1:0] f_col;
	logic          q_full, q_empty, q_pop;
	logic [QW-1:0] q_head;
	op_flags_t     b_flags;
	logic [CW-1:0] b_col;

	hsm3_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW       (CW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (f_push),
		.q_flags(f_flags),
		.q_col  (f_col)
	);

	// The queue lets the front end keep taking pixels, until it fills, while
	// the result consumer stalls the back end, and vice versa.
	hsm3_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_data({f_flags, f_col}),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	assign b_flags = op_flags_t'(q_head[QW-1:CW]);
	assign b_col   = q_head[CW-1:0];

	// Back end: reads the two stored mask rows for the column, forms the new
	// window column, writes the rows back shifted by one, and produces at most
	// one result per operation into the output register.
	hsm3_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW       (CW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_flags(b_flags),
		.q_col  (b_col),
		.q_pop  (q_pop),
		.res    (res)
	);

endmodule

// File: sim/hsv_skin_mask_median3_core_tb.sv
// ----------------------------------------------------------------------------
// hsv_skin_mask_median3_core_tb: self-checking bench for the skin mask core
// Streams HSV frames into the core under random back-pressure and compares
// every filtered mask bit, row end and frame end with a cycle-free model of
// the threshold, the 3x3 majority and the edge replication kept in here.
// ----------------------------------------------------------------------------
module hsv_skin_mask_median3_core_tb;
	import hsm3_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1080;
	localparam int REPORT_LIMIT  = 10;
	localparam int IDLE_PCT      = 23;

	typedef struct packed {
		bit             mode;
		bit [PIX_W-1:0] hue;
		bit [PIX_W-1:0] sat;
		bit [PIX_W-1:0] bright;
	} pix_item_t;

	typedef struct packed {
		bit skin_bit;
		bit row_end;
		bit frame_end;
	} mask_res_t;

	logic clk = 1'b0;
	logic arst_n;

	hsm3_pix_if pix();
	hsm3_cfg_if cfg();
	hsm3_res_if res();

	hsv_skin_mask_median3_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.res    (res)
	);

	// Mirror of the register file and of the filter state, updated on every
	// accepted transfer in the order in which the core sees them.
	bit [CFG_DATA_W-1:0] reg_file [8];
	bit                  upper_row [MAX_WIDTH_DEF];
	bit                  middle_row [MAX_WIDTH_DEF];
	bit [8:0]            mask_window;
	int unsigned         col_pos;
	int unsigned         row_pos;
	int unsigned         items_taken;
	mask_res_t           pending_masks [$];

	int unsigned mask_errors;
	int unsigned cycle_count;
	bit          source_calm;
	bit          sink_calm;
	int unsigned hold_request;
	int unsigned hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_masks.size());
			$display("hsv_skin_mask_median3_core_tb: done, errors");
			$finish;
		end
	end

	// Result sink. A hold-off request from the test sequence is latched here
	// and counted down in this process alone; otherwise ready drops at random
	// unless the sink has been told to stay calm.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= sink_calm || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Result checker. Sampling at the falling edge sees valid and ready as they
	// stand for the coming rising edge, so no race with the core's registers.
	always @(negedge clk) begin : check_results
		mask_res_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_masks.size() == 0) begin
				mask_errors++;
				if (mask_errors <= REPORT_LIMIT)
					$display("unexpected result skin=%0b row_end=%0b frame_end=%0b",
						res.skin_bit, res.row_end, res.frame_end);
			end else begin
				want = pending_masks.pop_front();
				if (res.skin_bit !== want.skin_bit || res.row_end !== want.row_end ||
						res.frame_end !== want.frame_end) begin
					mask_errors++;
					if (mask_errors <= REPORT_LIMIT)
						$display("mask mismatch (skin/row/frame): expected %0b%0b%0b, got %0b%0b%0b",
							want.skin_bit, want.row_end, want.frame_end,
							res.skin_bit, res.row_end, res.frame_end);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Model of the filter
	// ------------------------------------------------------------------------

	// Out-of-range sizes are folded the same way the core folds them: a zero
	// width or height acts as one, a width beyond the line store as its depth.
	function automatic int unsigned eff_width();
		int unsigned w;
		w = reg_file[REG_FRAME_WIDTH][FW_W-1:0];
		if (w == 0)
			w = 1;
		else if (w > MAX_WIDTH_DEF)
			w = MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = reg_file[REG_FRAME_HEIGHT][FH_W-1:0];
		return (h == 0) ? 1 : h;
	endfunction

	function automatic int unsigned ones3(input bit [2:0] c);
		return int'(c[0]) + int'(c[1]) + int'(c[2]);
	endfunction

	function automatic bit in_window(input bit [PIX_W-1:0] v, input cfg_reg_t lo_reg,
			input cfg_reg_t hi_reg);
		return v >= reg_file[lo_reg][PIX_W-1:0] && v <= reg_file[hi_reg][PIX_W-1:0];
	endfunction

	// Majority of nine: skin when at least five of the window bits are set.
	function automatic void push_mask(input int unsigned ones, input bit row_end,
			input bit frame_end);
		mask_res_t m;
		m.skin_bit = (ones >= 5);
		m.row_end = row_end;
		m.frame_end = frame_end;
		pending_masks.push_back(m);
	endfunction

	// Advances the mirrored filter by one accepted transfer and queues the
	// mask bit it completes, if any. The window holds three columns, oldest in
	// the top bits; each column is {row below, centre row, row above}.
	function automatic void predict_mask_item(input pix_item_t it);
		int unsigned w, h, r, j;
		bit up, mid, nb;
		bit [2:0] column;
		w = eff_width();
		h = eff_height();
		r = row_pos;
		j = col_pos;
		// A flush tick while pixel rows are still due changes nothing.
		if (r < h && it.mode)
			return;
		items_taken++;
		// Past the flush row: release the last column of the frame, with the
		// right edge replicated, and start over.
		if (r > h) begin
			push_mask(ones3(mask_window[5:3]) + 2 * ones3(mask_window[2:0]), 1'b1, 1'b1);
			mask_window = '0;
			row_pos = 0;
			col_pos = 0;
			return;
		end
		mid = middle_row[j];
		up = upper_row[j];
		// In the flush row any data is dropped and the bottom edge replicates.
		if (r < h)
			nb = in_window(it.hue, REG_HUE_LOW, REG_HUE_HIGH) &&
				in_window(it.sat, REG_SAT_LOW, REG_SAT_HIGH) &&
				in_window(it.bright, REG_VAL_LOW, REG_VAL_HIGH);
		else
			nb = mid;
		// The first centre row has no row above it: replicate the top edge.
		if (r == 1)
			up = mid;
		column = {nb, mid, up};
		// The first column of a row finishes the previous centre row.
		if (r >= 2 && j == 0)
			push_mask(ones3(mask_window[5:3]) + 2 * ones3(mask_window[2:0]), 1'b1, 1'b0);
		upper_row[j] = mid;
		middle_row[j] = nb;
		if (r >= 1) begin
			if (j == 0) begin
				mask_window = {column, column, column};
			end else begin
				mask_window = {mask_window[5:0], column};
				push_mask(ones3(mask_window[8:6]) + ones3(mask_window[5:3]) +
					ones3(mask_window[2:0]), 1'b0, 1'b0);
			end
		end
		if (j + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = j + 1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic pix_item_t px(input bit [PIX_W-1:0] h, input bit [PIX_W-1:0] s,
			input bit [PIX_W-1:0] b);
		return {1'b0, h, s, b};
	endfunction

	function automatic pix_item_t random_item();
		pix_item_t it;
		it.mode = 1'($urandom);
		it.hue = PIX_W'($urandom);
		it.sat = PIX_W'($urandom);
		it.bright = PIX_W'($urandom);
		return it;
	endfunction

	// Mostly inside the current window, with its bounds and the values just
	// outside them well represented, so that masks come out mixed.
	function automatic bit [PIX_W-1:0] pick_level(input cfg_reg_t lo_reg, input cfg_reg_t hi_reg);
		bit [PIX_W-1:0] lo, hi;
		lo = reg_file[lo_reg][PIX_W-1:0];
		hi = reg_file[hi_reg][PIX_W-1:0];
		case ($urandom_range(19, 0))
			0: return lo;
			1: return hi;
			2: return lo - 8'd1;
			3: return hi + 8'd1;
			4, 5: return PIX_W'($urandom);
			default: return (lo <= hi) ? PIX_W'($urandom_range(hi, lo)) : PIX_W'($urandom);
		endcase
	endfunction

	function automatic pix_item_t make_pixel();
		return px(pick_level(REG_HUE_LOW, REG_HUE_HIGH), pick_level(REG_SAT_LOW, REG_SAT_HIGH),
			pick_level(REG_VAL_LOW, REG_VAL_HIGH));
	endfunction

	function automatic void pick_window(output bit [PIX_W-1:0] lo, output bit [PIX_W-1:0] hi);
		case ($urandom_range(19, 0))
			0, 1: begin
				lo = 8'd0;
				hi = 8'd255;
			end
			2: begin
				// Empty window: low bound above the high bound.
				lo = PIX_W'($urandom_range(255, 1));
				hi = PIX_W'($urandom_range(lo - 1, 0));
			end
			default: begin
				lo = PIX_W'($urandom_range(200, 0));
				hi = PIX_W'($urandom_range(255, lo));
			end
		endcase
	endfunction

	// Register write. Valid is left high after the transfer; the caller lowers
	// it once the last register of a batch has gone.
	task automatic write_reg(input cfg_reg_t idx, input bit [CFG_DATA_W-1:0] data);
		bit taken;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do begin
			@(negedge clk);
			taken = cfg.ready;
			@(posedge clk);
		end while (!taken);
		reg_file[idx] = data;
	endtask

	// Writes all eight registers. Unused upper data bits carry random junk,
	// which the core must ignore.
	task automatic load_settings(input bit [PIX_W-1:0] hl, input bit [PIX_W-1:0] hh,
			input bit [PIX_W-1:0] sl, input bit [PIX_W-1:0] sh, input bit [PIX_W-1:0] vl,
			input bit [PIX_W-1:0] vh, input bit [FW_W-1:0] fw, input bit [FH_W-1:0] fh);
		bit [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_HUE_LOW, {junk[CFG_DATA_W-1:PIX_W], hl});
		write_reg(REG_HUE_HIGH, {junk[CFG_DATA_W-1:PIX_W], hh});
		write_reg(REG_SAT_LOW, {junk[CFG_DATA_W-1:PIX_W], sl});
		write_reg(REG_SAT_HIGH, {junk[CFG_DATA_W-1:PIX_W], sh});
		write_reg(REG_VAL_LOW, {junk[CFG_DATA_W-1:PIX_W], vl});
		write_reg(REG_VAL_HIGH, {junk[CFG_DATA_W-1:PIX_W], vh});
		write_reg(REG_FRAME_WIDTH, {junk[CFG_DATA_W-1:FW_W], fw});
		write_reg(REG_FRAME_HEIGHT, fh);
		cfg.valid <= 1'b0;
	endtask

	// Offers one item until it is taken, idling beforehand at random unless
	// the source is calm. Valid stays high after the transfer so that a
	// following item can go out back to back; wait_drained lowers it.
	task automatic send_item(input pix_item_t it);
		bit taken;
		while (!source_calm && $urandom_range(99, 0) < IDLE_PCT) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.mode <= it.mode;
		pix.hue <= it.hue;
		pix.sat <= it.sat;
		pix.bright <= it.bright;
		do begin
			@(negedge clk);
			taken = pix.ready;
			@(posedge clk);
		end while (!taken);
		predict_mask_item(it);
	endtask

	// Stops offering and waits for every expected result, then lets the
	// core's pipeline settle so that it is idle for a register write.
	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (pending_masks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Completes the current frame from wherever it stands: pixels while rows
	// are due, then the flush row, then the closing item. With noise, stray
	// flush ticks are mixed among the pixels and the flush row carries
	// pixels, which the core treats as flush ticks.
	task automatic finish_frame(input int unsigned noise_pct);
		pix_item_t it;
		do begin
			if (row_pos < eff_height()) begin
				if ($urandom_range(99, 0) < noise_pct) begin
					it = random_item();
					it.mode = 1'b1;
					send_item(it);
				end
				send_item(make_pixel());
			end else begin
				it = random_item();
				if (row_pos == eff_height() && $urandom_range(99, 0) >= noise_pct)
					it.mode = 1'b1;
				send_item(it);
			end
		end while (row_pos != 0 || col_pos != 0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Threshold bounds as left by reset, probed on and just beyond each bound.
	task automatic test_default_bounds();
		pix_item_t probes [12];
		probes = '{px(1, 100, 100), px(2, 100, 100), px(15, 100, 100), px(16, 100, 100),
			px(8, 59, 100), px(8, 60, 100), px(8, 200, 100), px(8, 201, 100),
			px(8, 100, 39), px(8, 100, 40), px(8, 100, 200), px(8, 100, 201)};
		write_reg(REG_FRAME_WIDTH, 12'd4);
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		cfg.valid <= 1'b0;
		foreach (probes[i])
			send_item(probes[i]);
		finish_frame(0);
		wait_drained();
	endtask

	// Zero width and height fold to one; single column and single row frames;
	// the field extremes with every window fully open.
	task automatic test_size_extremes();
		load_settings(0, 255, 0, 255, 0, 255, 0, 0);
		send_item(px(0, 0, 0));
		finish_frame(0);
		wait_drained();
		load_settings(0, 255, 0, 255, 0, 255, 1, 2);
		send_item(px(255, 255, 255));
		send_item(px(0, 255, 0));
		finish_frame(0);
		wait_drained();
		load_settings(0, 255, 0, 255, 0, 255, 2, 1);
		send_item(px(255, 0, 255));
		finish_frame(0);
		wait_drained();
	endtask

	// An empty hue window masks everything out; a one-value window still
	// lets its single value through.
	task automatic test_window_extremes();
		load_settings(20, 10, 0, 255, 0, 255, 3, 3);
		finish_frame(0);
		wait_drained();
		load_settings(255, 255, 0, 0, 0, 255, 3, 3);
		finish_frame(0);
		wait_drained();
	endtask

	// Flush ticks among the pixel rows are ignored; pixels in the flush row
	// stand in for flush ticks and their data is dropped.
	task automatic test_flush_rules();
		pix_item_t it;
		load_settings(0, 127, 0, 255, 64, 255, 3, 2);
		repeat (6) begin
			it = random_item();
			it.mode = 1'b1;
			send_item(it);
			send_item(make_pixel());
		end
		repeat (3) begin
			it = random_item();
			it.mode = 1'b0;
			send_item(it);
		end
		send_item(random_item());
		wait_drained();
	endtask

	// Height lowered in the middle of a frame, once below the current row so
	// the next item closes the frame, and once onto the current row so the
	// rest of that row becomes the flush row. The sender pauses for a full
	// drain before each change.
	task automatic test_height_cut();
		load_settings(0, 127, 0, 255, 64, 255, 4, 12'd4095);
		repeat (14) send_item(make_pixel());
		wait_drained();
		load_settings(0, 127, 0, 255, 64, 255, 4, 1);
		send_item(random_item());
		wait_drained();
		load_settings(0, 127, 0, 255, 64, 255, 4, 12'd4095);
		repeat (9) send_item(make_pixel());
		wait_drained();
		load_settings(0, 127, 0, 255, 64, 255, 4, 2);
		finish_frame(0);
		wait_drained();
	endtask

	// The sink holds off for a long stretch while the source keeps offering,
	// so the internal queue fills and the core must stall its input.
	task automatic test_backpressure();
		load_settings(0, 160, 30, 255, 0, 200, 16, 6);
		source_calm = 1'b1;
		sink_calm = 1'b1;
		hold_request = 150;
		finish_frame(0);
		wait_drained();
		source_calm = 1'b0;
		sink_calm = 1'b0;
	endtask

	// A width beyond the line store acts as its full depth, so the first row
	// must not wrap early. The width is then lowered part way through that
	// row, which wraps it at once, and the frame is finished at the small size.
	task automatic test_widest_row();
		load_settings(0, 180, 0, 255, 0, 255, 11'd2047, 12'd4095);
		repeat (40) send_item(make_pixel());
		wait_drained();
		load_settings(0, 180, 0, 255, 0, 255, 8, 2);
		finish_frame(0);
		wait_drained();
	endtask

	// Random settings and well-formed frames with a little noise. The first
	// stretch runs with no idling on either side.
	task automatic test_random_frames();
		int unsigned start_count;
		bit [PIX_W-1:0] hl, hh, sl, sh, vl, vh;
		bit [FW_W-1:0] fw;
		bit [FH_W-1:0] fh;
		start_count = items_taken;
		source_calm = 1'b1;
		sink_calm = 1'b1;
		while (items_taken - start_count < RANDOM_ITEMS) begin
			if (items_taken - start_count >= 250) begin
				source_calm = 1'b0;
				sink_calm = 1'b0;
			end
			pick_window(hl, hh);
			pick_window(sl, sh);
			pick_window(vl, vh);
			case ($urandom_range(19, 0))
				0: begin
					fw = 0;
					fh = FH_W'($urandom_range(4, 0));
				end
				1: begin
					fw = 1;
					fh = FH_W'($urandom_range(8, 1));
				end
				2, 3: begin
					fw = FW_W'($urandom_range(40, 20));
					fh = FH_W'($urandom_range(3, 1));
				end
				default: begin
					fw = FW_W'($urandom_range(12, 2));
					fh = FH_W'($urandom_range(6, 1));
				end
			endcase
			load_settings(hl, hh, sl, sh, vl, vh, fw, fh);
			// Now and then the source stops part way and waits for a full drain.
			if ($urandom_range(7, 0) == 0) begin
				repeat ($urandom_range(eff_width() * eff_height() - 1, 0))
					send_item(make_pixel());
				wait_drained();
			end
			finish_frame(6);
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.mode = 1'b0;
		pix.hue = '0;
		pix.sat = '0;
		pix.bright = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_HUE_LOW;
		cfg.data = '0;
		res.ready = 1'b0;

		reg_file[REG_HUE_LOW] = HUE_LOW_RST;
		reg_file[REG_HUE_HIGH] = HUE_HIGH_RST;
		reg_file[REG_SAT_LOW] = SAT_LOW_RST;
		reg_file[REG_SAT_HIGH] = SAT_HIGH_RST;
		reg_file[REG_VAL_LOW] = VAL_LOW_RST;
		reg_file[REG_VAL_HIGH] = VAL_HIGH_RST;
		reg_file[REG_FRAME_WIDTH] = WIDTH_RST;
		reg_file[REG_FRAME_HEIGHT] = HEIGHT_RST;
		mask_window = '0;
		row_pos = 0;
		col_pos = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_default_bounds();
		test_size_extremes();
		test_window_extremes();
		test_flush_rules();
		test_height_cut();
		test_backpressure();
		test_widest_row();
		test_random_frames();

		wait_drained();
		if (mask_errors == 0 && pending_masks.size() == 0)
			$display("hsv_skin_mask_median3_core_tb: done, clean");
		else
			$display("hsv_skin_mask_median3_core_tb: done, errors");
		$finish;
	end

endmodule

// File: hsv_skin_mask_median3_core.f
design/hsm3_pkg.sv
design/hsm3_if.sv
design/hsm3_ram.sv
design/hsm3_queue.sv
design/hsm3_front.sv
design/hsm3_back.sv
design/hsv_skin_mask_median3_core.sv
sim/hsv_skin_mask_median3_core_tb.sv
